// ===== hw/rtl/wnms_pkg.sv =====
// Shared types and codes for the weighted neighbor move selector.
package wnms_pkg;

    localparam int CellW   = 10;
    localparam int SlotW   = 3;
    localparam int WeightW = 16;
    localparam int AgentW  = 20;
    localparam int RandW   = 16;
    localparam int ProbW   = 17;
    localparam int StatusW = 2;

    typedef enum logic
    {
        MODE_LOAD = 1'b0,
        MODE_MOVE = 1'b1
    } mode_t;

    typedef enum logic [StatusW-1:0]
    {
        STATUS_CHOSEN = 2'd0,
        STATUS_NONE   = 2'd1,
        STATUS_LOAD   = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_LOAD,
        S_READ,
        S_TAIL,
        S_TEST,
        S_CMP,
        S_PICK,
        S_DONE
    } state_t;

endpackage

// ===== hw/rtl/weighted_neighbor_move_select_top.sv =====
// Flow: a load goes through S_LOAD to S_DONE, and a rejected move goes straight to S_DONE; a move
// reads the NEIGHBORS+1 slots one per cycle in S_READ through the single weight memory port,
// then passes S_TAIL and S_TEST, and S_CMP and S_PICK if the access test passes, before S_DONE.
// The unit takes one item at a time, and S_DONE holds until the output register is free.
// Reset: control state, out_valid and move_prob clear at once; the output data registers and
// the weight memory are not cleared, and each weight entry is undefined until loaded.
module weighted_neighbor_move_select_top #(
    parameter int NEIGHBORS = 6,
    parameter int CELLS     = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wnms_pkg::ProbW-1:0]         move_prob,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic [wnms_pkg::CellW-1:0]         cell_req,
    input  logic [wnms_pkg::SlotW-1:0]         slot,
    input  logic [wnms_pkg::WeightW-1:0]       weight,
    input  logic                               ice,
    input  logic [wnms_pkg::AgentW-1:0]        agent,
    input  logic                               alive,
    input  logic [wnms_pkg::RandW-1:0]         rand_move,
    input  logic [wnms_pkg::RandW-1:0]         rand_access,
    input  logic [wnms_pkg::RandW-1:0]         rand_pick,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [wnms_pkg::AgentW-1:0]        agent_out,
    output logic [wnms_pkg::CellW-1:0]         from_cell,
    output logic [wnms_pkg::SlotW-1:0]         chosen_slot,
    output logic                               do_move,
    output logic [wnms_pkg::StatusW-1:0]       status
);

    import wnms_pkg::*;

    localparam int Slots = NEIGHBORS + 1;
    localparam int Depth = CELLS * Slots;
    localparam int AW    = $clog2(Depth);
    localparam int CW    = $clog2(Slots);
    localparam int MemW  = WeightW + 1;
    localparam int ProdW = 2 * (WeightW + 1);
    localparam int TgtW  = 2 * WeightW + 3;
    localparam logic [CW-1:0] LastIdx = CW'(NEIGHBORS);

    state_t state_reg, state_next;

    logic [MemW-1:0]    mem [0:Depth-1];
    logic [MemW-1:0]    mem_q_reg;
    logic               mem_we;

    logic [ProbW-1:0]   move_prob_reg;
    logic [AW-1:0]      addr_reg;
    logic [CW-1:0]      cnt_reg;
    logic               rd_vld_reg;
    logic [CW-1:0]      rd_idx_reg;
    logic               load_ok_reg;
    logic [MemW-1:0]    wdata_reg;
    logic [AgentW-1:0]  agent_reg;
    logic [CellW-1:0]   cell_reg;
    logic [RandW-1:0]   access_reg;
    logic [RandW-1:0]   pick_reg;

    logic [WeightW-1:0] wt_reg [0:NEIGHBORS];
    logic [WeightW-1:0] prev_reg;
    logic               iced_reg;
    logic [CW-1:0]      empty_reg;
    logic signed [ProdW-1:0] prod_reg;
    logic [NEIGHBORS:0] hit_reg;

    logic [SlotW-1:0]   res_slot_reg;
    logic               res_move_reg;
    status_t            res_status_reg;

    logic               out_valid_reg;
    logic [AgentW-1:0]  out_agent_reg;
    logic [CellW-1:0]   out_cell_reg;
    logic [SlotW-1:0]   out_slot_reg;
    logic               out_move_reg;
    logic [StatusW-1:0] out_status_reg;

    logic               accept;
    logic               reject;
    logic               access_ok;
    logic               out_free;
    logic               out_load;
    logic [31:0]        base_full;
    logic signed [ProdW-1:0] span;
    logic signed [TgtW-1:0] target;
    logic [NEIGHBORS:0] hit;
    logic [CW-1:0]      pick_idx;

    // ---------------------------------------------------------------- decode
    assign accept    = in_valid && in_ready;
    assign reject    = (32'(cell_req) >= 32'(CELLS)) || !alive
                       || !(ProbW'(rand_move) < move_prob_reg);
    assign base_full = 32'(cell_req) * 32'(Slots);
    assign access_ok = (32'(access_reg) * 32'(NEIGHBORS)) > (32'(empty_reg) << 16);
    assign out_free  = !out_valid_reg || out_ready;

    assign span   = ProdW'(wt_reg[NEIGHBORS]) - ProdW'(wt_reg[0]);
    assign target = $signed({3'b000, wt_reg[0], 16'h0000}) + TgtW'(prod_reg);

    always_comb
    begin
        for (int i = 0; i <= NEIGHBORS; i++)
        begin
            hit[i] = target < $signed({3'b000, wt_reg[i], 16'h0000});
        end
    end

    // first slot whose weight lies above the target
    always_comb
    begin
        pick_idx = '0;
        for (int i = NEIGHBORS; i >= 0; i--)
        begin
            if (hit_reg[i])
            begin
                pick_idx = CW'(i);
            end
        end
    end

    // ---------------------------------------------------------------- state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (reject)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_LOAD: state_next = S_DONE;
            S_READ:
            begin
                if (cnt_reg == LastIdx)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL: state_next = S_TEST;
            S_TEST: state_next = access_ok ? S_CMP : S_DONE;
            S_CMP:  state_next = S_PICK;
            S_PICK: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE: in_ready = 1'b1;
            S_LOAD: mem_we   = load_ok_reg;
            S_DONE: out_load = out_free;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            move_prob_reg <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == S_READ);
            if (cfg_valid && cfg_ready)
            begin
                move_prob_reg <= move_prob;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- weight memory
    // slot 0 entries carry the cell's ice flag in the top bit
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= wdata_reg;
        end
        mem_q_reg <= mem[addr_reg];
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            agent_reg   <= agent;
            cell_reg    <= cell_req;
            access_reg  <= rand_access;
            pick_reg    <= rand_pick;
            cnt_reg     <= '0;
            wdata_reg   <= {ice && (slot == '0), weight};
            load_ok_reg <= (32'(cell_req) < 32'(CELLS)) && (32'(slot) <= 32'(NEIGHBORS));
            if (mode == MODE_LOAD)
            begin
                addr_reg <= AW'(base_full + 32'(slot));
            end
            else
            begin
                addr_reg <= AW'(base_full);
            end
            if (mode == MODE_MOVE && reject)
            begin
                res_slot_reg   <= '0;
                res_move_reg   <= 1'b0;
                res_status_reg <= STATUS_NONE;
            end
        end

        if (state_reg == S_LOAD)
        begin
            res_slot_reg   <= '0;
            res_move_reg   <= 1'b0;
            res_status_reg <= load_ok_reg ? STATUS_LOAD : STATUS_NONE;
        end

        // advance the read address one slot per cycle
        if (state_reg == S_READ)
        begin
            addr_reg <= AW'(addr_reg + 1'b1);
            cnt_reg  <= CW'(cnt_reg + 1'b1);
        end
        rd_idx_reg <= cnt_reg;

        if (rd_vld_reg)
        begin
            wt_reg[rd_idx_reg] <= mem_q_reg[WeightW-1:0];
            prev_reg           <= mem_q_reg[WeightW-1:0];
            if (rd_idx_reg == '0)
            begin
                iced_reg  <= mem_q_reg[WeightW];
                empty_reg <= '0;
            end
            else if (mem_q_reg[WeightW-1:0] == prev_reg)
            begin
                empty_reg <= CW'(empty_reg + 1'b1);
            end
        end

        if (state_reg == S_TEST)
        begin
            prod_reg <= span * $signed(ProdW'(pick_reg));
            if (!access_ok)
            begin
                res_slot_reg   <= '0;
                res_move_reg   <= 1'b0;
                res_status_reg <= STATUS_NONE;
            end
        end

        if (state_reg == S_CMP)
        begin
            hit_reg <= hit;
        end

        if (state_reg == S_PICK)
        begin
            if (hit_reg == '0)
            begin
                res_slot_reg   <= '0;
                res_move_reg   <= 1'b0;
                res_status_reg <= STATUS_NONE;
            end
            else
            begin
                res_slot_reg   <= SlotW'(pick_idx);
                res_move_reg   <= (pick_idx != '0) && !iced_reg;
                res_status_reg <= STATUS_CHOSEN;
            end
        end

        if (out_load)
        begin
            out_agent_reg  <= agent_reg;
            out_cell_reg   <= cell_reg;
            out_slot_reg   <= res_slot_reg;
            out_move_reg   <= res_move_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign agent_out   = out_agent_reg;
    assign from_cell   = out_cell_reg;
    assign chosen_slot = out_slot_reg;
    assign do_move     = out_move_reg;
    assign status      = out_status_reg;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted transaction left the unit idle");

    a_empty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TEST |-> 32'(empty_reg) <= 32'(NEIGHBORS))
        else $error("empty neighbor count exceeds neighbor count");

    a_move_is_chosen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_move_reg)
        |-> (res_status_reg == STATUS_CHOSEN && res_slot_reg != '0))
        else $error("move flagged without a chosen neighbor");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result presented outside the done state");
`endif

endmodule
